[src/lktf_pkg.sv]
// ----------------------------------------------------------------------------
// lktf_pkg: shared types and constants for the keystream descrambler
// Payload structs, register indexes, generator constants, tag magic words
// and the state machine encodings used by the framer and the key generator.
// ----------------------------------------------------------------------------
package lktf_pkg;

    // Generator recurrence and keystream shaping
    localparam int unsigned LCG_MUL     = 1597;
    localparam int unsigned LCG_INC     = 51749;
    localparam int unsigned LCG_MOD     = 244944;
    localparam int unsigned KEY_MUL     = 301593171;
    localparam int unsigned KEY_SHIFT_S = 24;
    localparam int unsigned KEY_SHIFT_K = 17;

    // Operand widths of the shared multiplier
    localparam int unsigned MUL_A_W = 32;
    localparam int unsigned MUL_B_W = $clog2(KEY_MUL + 1);
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    // Modulo by reciprocal: LCG_MOD = MOD_ODD << MOD_TZ, and the quotient of a
    // 32-bit x is ((x >> MOD_TZ) * RECIP_MUL) >> RECIP_SHIFT, exact for every x
    // because RECIP_SHIFT covers the 28-bit numerator plus the divisor bits.
    localparam int unsigned     MOD_TZ      = 4;
    localparam int unsigned     MOD_ODD     = LCG_MOD >> MOD_TZ;
    localparam int unsigned     RECIP_SHIFT = 42;
    localparam longint unsigned RECIP_MUL   =
        ((64'd1 << RECIP_SHIFT) + 64'(MOD_ODD) - 64'd1) / 64'(MOD_ODD);
    localparam int unsigned     QUOT_W      =
        $clog2(64'hFFFF_FFFF / 64'(LCG_MOD) + 64'd1);

    // Tag header layout
    localparam int unsigned HDR_LEN       = 12;
    localparam int unsigned MAGIC_LAST    = 3;
    localparam int unsigned LEN_FIRST     = 8;
    localparam int unsigned LEN_LAST      = 11;
    localparam logic [31:0] MAGIC_TEXT    = 32'h5462_4D43;
    localparam logic [31:0] MAGIC_MATRIX  = 32'h4D62_4D43;
    localparam logic [31:0] MAGIC_POINTER = 32'h5062_4D43;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_SEED_KEY      = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_DESCRAMBLE_ON = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_TEXT    = 2'd1,
        KIND_MATRIX  = 2'd2,
        KIND_POINTER = 2'd3
    } tag_kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_section;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  tag_kind;
        logic        header_done;
        logic [31:0] tag_length;
        logic        tag_end;
        logic        halted;
        logic        section_end;
    } result_t;

    // Key generator report back to the framer
    typedef struct packed {
        logic        done;
        logic [7:0]  key_byte;
        logic [31:0] state;
    } kg_report_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } fsm_state_t;

    typedef enum logic [2:0] {
        KG_IDLE,
        KG_MUL,
        KG_DIV,
        KG_MOD,
        KG_KEY,
        KG_FIN
    } kg_state_t;

    function automatic tag_kind_t kind_of_magic(input logic [31:0] magic);
        tag_kind_t kind;
        kind = KIND_NONE;
        if (magic == MAGIC_TEXT)
            kind = KIND_TEXT;
        else if (magic == MAGIC_MATRIX)
            kind = KIND_MATRIX;
        else if (magic == MAGIC_POINTER)
            kind = KIND_POINTER;
        return kind;
    endfunction

endpackage

[src/lktf_keygen.sv]
// ----------------------------------------------------------------------------
// lktf_keygen: generator step and keystream byte on one shared multiplier
// Multiply-add, form the modulo quotient by reciprocal multiply, subtract the
// quotient times the modulus, multiply by the keystream constant, then shape
// the key byte.
// ----------------------------------------------------------------------------
module lktf_keygen
    import lktf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] state_in,
    output kg_report_t  report
);

    kg_state_t           kg_state_reg, kg_state_next;
    logic [31:0]         acc_reg, acc_next;
    logic [31:0]         s_reg, s_next;
    logic [QUOT_W-1:0]   quot_reg, quot_next;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod;
    logic [31:0]         diff;
    logic [31:0]         mix;

    // Shared multiplier operands, picked by the sequencer step
    always_comb
    begin
        mul_a = acc_reg;
        mul_b = MUL_B_W'(KEY_MUL);
        unique case (kg_state_reg)
            KG_MUL:
            begin
                mul_b = MUL_B_W'(LCG_MUL);
            end
            KG_DIV:
            begin
                mul_a = acc_reg >> MOD_TZ;
                mul_b = MUL_B_W'(RECIP_MUL);
            end
            KG_MOD:
            begin
                mul_a = MUL_A_W'(quot_reg);
                mul_b = MUL_B_W'(LCG_MOD);
            end
            default:
            begin
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign diff = {acc_reg[31-8:0], 8'd0} - s_reg;
    assign mix  = {1'b0, diff[31:1]} + s_reg;

    always_comb
    begin
        kg_state_next = kg_state_reg;
        unique case (kg_state_reg)
            KG_IDLE: if (start) kg_state_next = KG_MUL;
            KG_MUL:  kg_state_next = KG_DIV;
            KG_DIV:  kg_state_next = KG_MOD;
            KG_MOD:  kg_state_next = KG_KEY;
            KG_KEY:  kg_state_next = KG_FIN;
            KG_FIN:  kg_state_next = KG_IDLE;
            default: kg_state_next = KG_IDLE;
        endcase
    end

    always_comb
    begin
        acc_next  = acc_reg;
        s_next    = s_reg;
        quot_next = quot_reg;
        unique case (kg_state_reg)
            KG_IDLE:
            begin
                if (start)
                    acc_next = state_in;
            end
            KG_MUL:
            begin
                acc_next = prod[31:0] + 32'(LCG_INC);
            end
            KG_DIV:
            begin
                quot_next = prod[RECIP_SHIFT +: QUOT_W];
            end
            KG_MOD:
            begin
                acc_next = acc_reg - prod[31:0];
            end
            KG_KEY:
            begin
                s_next = prod[KEY_SHIFT_S +: 32];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kg_state_reg <= KG_IDLE;
        else
            kg_state_reg <= kg_state_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        s_reg    <= s_next;
        quot_reg <= quot_next;
    end

    assign report.done     = (kg_state_reg == KG_FIN);
    assign report.key_byte = mix[KEY_SHIFT_K +: 8];
    assign report.state    = acc_reg;

endmodule

[src/lcg_keystream_descramble_tag_framer_unit.sv]
// ----------------------------------------------------------------------------
// lcg_keystream_descramble_tag_framer_unit: section byte descrambler and framer
// Descramble each payload byte with a generator keystream and cut the
// descrambled stream into tags with twelve-byte headers.
// ----------------------------------------------------------------------------
// Descrambling: the key generator's five steps on one multiplier, multiply-add,
//   reciprocal quotient, remainder, keystream multiply and shaping, then the
//   result register; no new byte is taken until the result is registered.
// Pass-through (descramble_on = 0): the held byte skips the key generator.
// A finished result waits in the output register while the next byte is taken.
// Reset is asynchronous, active low: clears control state, sets descramble_on.
// ----------------------------------------------------------------------------
module lcg_keystream_descramble_tag_framer_unit
    import lktf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,

    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    // Configuration registers
    logic [31:0] seed_key_reg;
    logic        descramble_on_reg;

    // Sequencer and held transaction
    fsm_state_t  state_reg, state_next;
    item_t       item_reg;
    logic [7:0]  key_reg;

    // Generator and framing state
    logic [31:0] gen_state_reg, gen_state_next;
    logic        fresh_reg, fresh_next;
    logic [31:0] magic_reg, magic_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] offset_reg, offset_next;
    tag_kind_t   kind_reg, kind_next;
    logic        halt_reg, halt_next;

    // Output register
    logic        result_valid_reg, result_valid_next;
    result_t     result_reg, result_comb;

    logic        item_take;
    logic        out_free;
    logic        emit;
    kg_report_t  kg_report;
    logic [31:0] kg_seed;
    logic [7:0]  plain;

    assign cfg_ready  = 1'b1;
    assign item_stall = (state_reg != ST_IDLE);
    assign item_take  = item_valid && !item_stall;

    // Output slot is free when empty or when its transaction leaves this cycle
    assign out_free = !result_valid_reg || !result_stall;
    assign emit     = (state_reg == ST_EMIT) && out_free;

    // Start a section from the seed, otherwise continue from the last state
    assign kg_seed = fresh_reg ? seed_key_reg : gen_state_reg;

    lktf_keygen u_keygen
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (item_take && descramble_on_reg),
        .state_in (kg_seed),
        .report   (kg_report)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                    state_next = descramble_on_reg ? ST_RUN : ST_EMIT;
            end
            ST_RUN:
            begin
                if (kg_report.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- framer
    // Build the result and next framing state from the held byte and key.
    always_comb
    begin
        logic [31:0] off;

        off          = offset_reg;
        plain        = item_reg.in_byte ^ (descramble_on_reg ? key_reg : 8'd0);

        magic_next   = magic_reg;
        length_next  = length_reg;
        offset_next  = offset_reg;
        kind_next    = kind_reg;
        halt_next    = halt_reg;
        fresh_next   = fresh_reg;

        result_comb             = '0;
        result_comb.out_byte    = plain;
        result_comb.section_end = item_reg.end_of_section;

        if (descramble_on_reg && !halt_reg)
        begin
            // Collect header bytes, little-endian
            if (off < 32'(MAGIC_LAST + 1))
            begin
                case (off[1:0])
                    2'd0:    magic_next[7:0]   = plain;
                    2'd1:    magic_next[15:8]  = plain;
                    2'd2:    magic_next[23:16] = plain;
                    default: magic_next[31:24] = plain;
                endcase
            end
            else if (off >= 32'(LEN_FIRST) && off <= 32'(LEN_LAST))
            begin
                case (off[1:0])
                    2'd0:    length_next[7:0]   = plain;
                    2'd1:    length_next[15:8]  = plain;
                    2'd2:    length_next[23:16] = plain;
                    default: length_next[31:24] = plain;
                endcase
            end

            // Unknown magic stops framing
            if (off == 32'(MAGIC_LAST))
            begin
                kind_next = kind_of_magic(magic_next);
                if (kind_next == KIND_NONE)
                    halt_next = 1'b1;
            end

            // A length shorter than the header stops framing
            if (off == 32'(LEN_LAST))
            begin
                if (length_next < 32'(HDR_LEN))
                    halt_next = 1'b1;
                else
                    result_comb.header_done = 1'b1;
            end

            if (!halt_next)
            begin
                result_comb.tag_kind = kind_next;
                if (off >= 32'(LEN_LAST))
                    result_comb.tag_length = length_next;
                if (off >= 32'(LEN_LAST) && (off + 32'd1) == length_next)
                begin
                    // Last byte of the tag: start a fresh header next
                    result_comb.tag_end = 1'b1;
                    magic_next  = '0;
                    length_next = '0;
                    offset_next = '0;
                    kind_next   = KIND_NONE;
                end
                else
                begin
                    offset_next = off + 32'd1;
                end
            end
            else
            begin
                result_comb.header_done = 1'b0;
            end
        end

        if (descramble_on_reg)
            result_comb.halted = halt_next;

        // Section end drops any partial tag and rearms the reseed
        if (item_reg.end_of_section)
        begin
            fresh_next  = 1'b1;
            magic_next  = '0;
            length_next = '0;
            offset_next = '0;
            kind_next   = KIND_NONE;
            halt_next   = 1'b0;
        end
    end

    // Advance the generator on key completion; consume the seed on acceptance
    always_comb
    begin
        gen_state_next = gen_state_reg;
        if (kg_report.done)
            gen_state_next = kg_report.state;
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (emit)
            result_valid_next = 1'b1;
        else if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_key_reg      <= '0;
            descramble_on_reg <= 1'b1;
            state_reg         <= ST_IDLE;
            gen_state_reg     <= '0;
            fresh_reg         <= 1'b1;
            magic_reg         <= '0;
            length_reg        <= '0;
            offset_reg        <= '0;
            kind_reg          <= KIND_NONE;
            halt_reg          <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SEED_KEY:      seed_key_reg      <= cfg_data;
                    REG_DESCRAMBLE_ON: descramble_on_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            state_reg        <= state_next;
            gen_state_reg    <= gen_state_next;
            result_valid_reg <= result_valid_next;

            if (item_take && descramble_on_reg)
                fresh_reg <= 1'b0;

            if (emit)
            begin
                fresh_reg  <= fresh_next;
                magic_reg  <= magic_next;
                length_reg <= length_next;
                offset_reg <= offset_next;
                kind_reg   <= kind_next;
                halt_reg   <= halt_next;
            end
        end
    end

    // Payload holding registers
    always_ff @(posedge clk)
    begin
        if (item_take)
            item_reg <= item;
        if (kg_report.done)
            key_reg <= kg_report.key_byte;
        if (emit)
            result_reg <= result_comb;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[bench/lcg_keystream_descramble_tag_framer_unit_tb.sv]
// ----------------------------------------------------------------------------
// lcg_keystream_descramble_tag_framer_unit_tb: self-checking descrambler bench
// Drives section bytes whose plain text is built as real tag headers and
// bodies, encrypted with a bench-side keystream. An in-bench predictor tracks
// the generator and the framer. Every result is checked field by field.
// ----------------------------------------------------------------------------
module lcg_keystream_descramble_tag_framer_unit_tb;
    import lktf_pkg::*;

    // Cycle budget: about 1200 bytes plus sender gaps and long receiver stalls
    // fit well inside this limit, with ample margin.
    localparam int CYCLE_LIMIT = 600_000;
    localparam int DRAIN_CYCLES = 40;

    // Indexes past the last register; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_NONE_FIRST = REG_DESCRAMBLE_ON + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_NONE_LAST  = '1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    item_t                  item = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data = '0;

    lcg_keystream_descramble_tag_framer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: register shadows, generator and framer
    // ------------------------------------------------------------------------
    logic [31:0] seed_reg       = '0;
    logic        descramble_en  = 1'b1;
    logic [31:0] gen_state      = '0;
    logic        reseed_pending = 1'b1;
    logic [31:0] magic_acc      = '0;
    logic [31:0] length_acc     = '0;
    logic [31:0] tag_offset     = '0;
    tag_kind_t   cur_kind       = KIND_NONE;
    logic        framing_halted = 1'b0;

    result_t     pending_results[$];
    logic [7:0]  section_bytes[$];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int bytes_sent      = 0;
    int results_seen    = 0;
    int error_count     = 0;
    int header_count    = 0;
    int tag_end_count   = 0;
    int halted_count    = 0;
    int section_count   = 0;
    int cycle_count     = 0;

    // One generator step: 32-bit wrapping multiply-add, then the modulo
    function automatic logic [31:0] lcg_advance(input logic [31:0] st);
        logic [31:0] t;
        t = st * 32'(LCG_MUL) + 32'(LCG_INC);
        return t % 32'(LCG_MOD);
    endfunction

    // Multiply-shift keystream byte from an already advanced state
    function automatic logic [7:0] keystream_byte(input logic [31:0] g);
        logic [63:0] p;
        logic [31:0] s;
        logic [31:0] t;
        logic [31:0] k;
        p = {32'b0, g} * 64'(KEY_MUL);
        s = 32'(p >> KEY_SHIFT_S);
        t = (g << 8) - s;
        k = ((t >> 1) + s) >> KEY_SHIFT_K;
        return k[7:0];
    endfunction

    // Key byte that the next accepted byte will see, without advancing
    function automatic logic [7:0] next_key_preview();
        return keystream_byte(lcg_advance(reseed_pending ? seed_reg : gen_state));
    endfunction

    function automatic tag_kind_t magic_to_kind(input logic [31:0] m);
        case (m)
            MAGIC_TEXT:    return KIND_TEXT;
            MAGIC_MATRIX:  return KIND_MATRIX;
            MAGIC_POINTER: return KIND_POINTER;
            default:       return KIND_NONE;
        endcase
    endfunction

    function automatic void clear_framing();
        magic_acc      = '0;
        length_acc     = '0;
        tag_offset     = '0;
        cur_kind       = KIND_NONE;
        framing_halted = 1'b0;
    endfunction

    // Advance the predictor by one byte and return the result it must cause
    function automatic result_t descramble_and_frame(input item_t it);
        result_t     r;
        logic [7:0]  d;
        logic [31:0] off;
        r = '0;
        r.out_byte    = it.in_byte;
        r.section_end = it.end_of_section;
        if (descramble_en)
        begin
            if (reseed_pending)
            begin
                gen_state      = seed_reg;
                reseed_pending = 1'b0;
            end
            gen_state  = lcg_advance(gen_state);
            d          = it.in_byte ^ keystream_byte(gen_state);
            r.out_byte = d;
            if (!framing_halted)
            begin
                off = tag_offset;
                if (off <= MAGIC_LAST)
                    magic_acc |= {24'b0, d} << (8 * off);
                else if (off >= LEN_FIRST && off <= LEN_LAST)
                    length_acc |= {24'b0, d} << (8 * (off - LEN_FIRST));
                if (off == MAGIC_LAST)
                begin
                    cur_kind = magic_to_kind(magic_acc);
                    if (cur_kind == KIND_NONE)
                        framing_halted = 1'b1;
                end
                if (off == LEN_LAST)
                begin
                    if (length_acc < HDR_LEN)
                        framing_halted = 1'b1;
                    else
                        r.header_done = 1'b1;
                end
                if (!framing_halted)
                begin
                    r.tag_kind = cur_kind;
                    if (off >= LEN_LAST)
                        r.tag_length = length_acc;
                    if (off >= LEN_LAST && off + 32'd1 == length_acc)
                    begin
                        r.tag_end = 1'b1;
                        clear_framing();
                    end
                    else
                        tag_offset = off + 32'd1;
                end
            end
            r.halted = framing_halted;
        end
        // A section end arms the reseed and drops any partial tag
        if (it.end_of_section)
        begin
            reseed_pending = 1'b1;
            clear_framing();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        error_count++;
        $display("MISMATCH at result %0d: %s got %0h want %0h",
                 results_seen, what, got, want);
    endtask

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            header_count  += result.header_done;
            tag_end_count += result.tag_end;
            halted_count  += result.halted;
            section_count += result.section_end;
            if (pending_results.size() == 0)
                flag_mismatch("unexpected result, out_byte", result.out_byte, '0);
            else
            begin
                want = pending_results.pop_front();
                if (result.out_byte !== want.out_byte)
                    flag_mismatch("out_byte", result.out_byte, want.out_byte);
                if (result.tag_kind !== want.tag_kind)
                    flag_mismatch("tag_kind", result.tag_kind, want.tag_kind);
                if (result.header_done !== want.header_done)
                    flag_mismatch("header_done", result.header_done, want.header_done);
                if (result.tag_length !== want.tag_length)
                    flag_mismatch("tag_length", result.tag_length, want.tag_length);
                if (result.tag_end !== want.tag_end)
                    flag_mismatch("tag_end", result.tag_end, want.tag_end);
                if (result.halted !== want.halted)
                    flag_mismatch("halted", result.halted, want.halted);
                if (result.section_end !== want.section_end)
                    flag_mismatch("section_end", result.section_end, want.section_end);
            end
        end
    end

    // Receiver back-pressure: redraw the stall every cycle
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < recv_stall_pct);

    // Hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Send one byte whose descrambled value is plain. Leave valid high on
    // return so back-to-back transactions need no gap.
    task automatic send_byte(input logic [7:0] plain, input logic eos);
        item_t it;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        it.end_of_section = eos;
        it.in_byte = descramble_en ? (plain ^ next_key_preview()) : plain;
        pending_results.push_back(descramble_and_frame(it));
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
        bytes_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every result is back and the block is quiet
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [31:0] data);
        wait_idle();
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_SEED_KEY)
            seed_reg = data;
        else if (idx == REG_DESCRAMBLE_ON)
            descramble_en = data[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Send the built section, marking its last byte as the section end if asked
    task automatic emit_section(input logic close_section);
        for (int i = 0; i < section_bytes.size(); i++)
            send_byte(section_bytes[i], close_section && i == section_bytes.size() - 1);
        section_bytes.delete();
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            section_bytes.push_back(w[8*i +: 8]);
    endtask

    task automatic push_noise(input int n);
        repeat (n) section_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic push_header(input logic [31:0] magic, input logic [31:0] len);
        push_word(magic);
        push_word($urandom);
        push_word(len);
    endtask

    function automatic logic [31:0] any_magic();
        case ($urandom_range(2))
            0:       return MAGIC_TEXT;
            1:       return MAGIC_MATRIX;
            default: return MAGIC_POINTER;
        endcase
    endfunction

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Plain text of one section: mostly complete tags, then an occasional
    // broken one (unknown magic, short length, huge length, truncation)
    // after which the section trails off in noise.
    task automatic build_section();
        int          ntags;
        int          pick;
        logic [31:0] len;
        logic        broken;
        ntags  = $urandom_range(1, 4);
        broken = 1'b0;
        for (int t = 0; t < ntags && !broken; t++)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                len = ($urandom_range(9) == 0) ? 32'(HDR_LEN) : 32'($urandom_range(13, 40));
                push_header(any_magic(), len);
                push_noise(len - HDR_LEN);
            end
            else if (pick < 68)
            begin
                // length far beyond the section: the tag is cut by the end
                len = $urandom | 32'h0000_0100;
                push_header(any_magic(), len);
                push_noise($urandom_range(0, 12));
                broken = 1'b1;
            end
            else if (pick < 78)
            begin
                if ($urandom_range(1) == 0)
                    push_word($urandom);
                else
                    push_word(any_magic() ^ (32'h1 << $urandom_range(31)));
                broken = 1'b1;
            end
            else if (pick < 88)
            begin
                push_header(any_magic(), 32'($urandom_range(0, HDR_LEN - 1)));
                broken = 1'b1;
            end
            else
            begin
                len = 32'($urandom_range(13, 40));
                push_header(any_magic(), len);
                push_noise($urandom_range(0, len - 13));
                broken = 1'b1;
            end
        end
        if (broken)
            push_noise($urandom_range(0, 3));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Header-only tag closing on the section end, all-ones seed
    task automatic test_header_only_tag();
        write_register(REG_DESCRAMBLE_ON, 32'd1);
        write_register(REG_SEED_KEY, 32'hFFFF_FFFF);
        push_word(MAGIC_TEXT);
        push_word(32'hFFFF_FFFF);
        push_word(32'(HDR_LEN));
        emit_section(1'b1);
    endtask

    // Near-miss magic halts the framer; the following byte stays halted
    task automatic test_unknown_magic();
        write_register(REG_SEED_KEY, 32'h0000_0000);
        push_word(MAGIC_MATRIX ^ 32'h8000_0000);
        push_noise(1);
        emit_section(1'b1);
    endtask

    // New seed written mid-section must wait for the next section start;
    // writes to indexes past the last register change nothing
    task automatic test_seed_change_mid_section();
        send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'($urandom_range(255)), 1'b0);
        write_register(REG_SEED_KEY, $urandom);
        write_register(REG_NONE_FIRST, 32'hFFFF_FFFF);
        write_register(REG_NONE_LAST, 32'h0000_0000);
        send_byte(8'($urandom_range(255)), 1'b1);
        send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    // Descrambling off: bytes pass unchanged, the section end still arms
    // the reseed, and framing resumes once descrambling is back on
    task automatic test_pass_through();
        write_register(REG_DESCRAMBLE_ON, 32'd0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h5A, 1'b0);
        write_register(REG_DESCRAMBLE_ON, 32'd1);
    endtask

    task automatic run_random_sections(input int sender_pct, input int stall_pct,
                                       input int quota);
        int stop_at;
        sender_idle_pct = sender_pct;
        recv_stall_pct  = stall_pct;
        stop_at         = bytes_sent + quota;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(9) < 2)
                write_register(REG_SEED_KEY, pick_seed());
            if ($urandom_range(11) == 0)
            begin
                // pass-through stretch, sometimes left open across the switch
                write_register(REG_DESCRAMBLE_ON, 32'd0);
                push_noise($urandom_range(1, 8));
                emit_section(1'($urandom_range(1)));
                write_register(REG_DESCRAMBLE_ON, 32'd1);
            end
            else
            begin
                build_section();
                emit_section(1'b1);
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_sections(24, 77, 380);
        run_random_sections(77, 24, 380);
        run_random_sections(0, 0, 390);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        sender_idle_pct = 24;
        recv_stall_pct  = 77;
        test_header_only_tag();
        test_unknown_magic();
        test_seed_change_mid_section();
        test_pass_through();
        test_random_traffic();

        // Hold for stragglers before the verdict
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            flag_mismatch("results never returned", pending_results.size(), '0);

        $display("Checked %0d results for %0d bytes over %0d sections",
                 results_seen, bytes_sent, section_count);
        $display("Saw %0d tag headers, %0d tag ends, %0d halted bytes",
                 header_count, tag_end_count, halted_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
